FILE: design/dss_pkg.sv
// shared constants and codes of the disk sweep scheduler
package dss_pkg;

  // cylinder width and store depth
  localparam int CYL_BITS     = 16;
  localparam int MAX_REQUESTS = 32;
  localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
  localparam int ADDR_W       = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REQUESTS);

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CYLINDER = 2'd1;
  localparam logic [CYL_BITS-1:0]  DEFAULT_MAX_CYL  = CYL_BITS'(4999);

  // sweep modes
  localparam logic MODE_UP_DOWN  = 1'b0;
  localparam logic MODE_CIRCULAR = 1'b1;

  // input request kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_START = 1'b1;

endpackage

FILE: design/dss_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module dss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

FILE: design/disk_sweep_scheduler_top.sv
// top level of the disk sweep scheduler (scan and circular scan ordering)
//
// Usage: the input channel (in_valid / in_stall) takes one request at a time.
// A load request (in_kind = 0) stores in_request_cylinder in a sorted store
// of MAX_REQUESTS entries; a load into a full store gives one result with
// out_rejected = 1. A start request (in_kind = 1) gives the service path:
// the head, then stored cylinders at or above the head ascending, then the
// lower ones descending (sweep mode) or max_cylinder, 0 and the lower ones
// ascending (circular mode). out_last marks the final cylinder; the store is
// then empty. Results leave on out_valid / out_stall through an output
// register; while the receiver stalls the walk simply waits.
// A load walks down from the top of the sorted ram, reading each entry and
// moving it up one place while it is larger than the new cylinder, then
// writes the new cylinder into the gap. A start first scans the store from
// the bottom for the first entry at or above the head, then sends the head,
// max_cylinder and 0 directly and each stored cylinder after its registered
// ram read. in_stall is high whenever a request is
// in work. The cfg port (index 0 sweep_mode, index 1 max_cylinder) is always
// ready. After reset the store is empty, sweep_mode is 0 and max_cylinder is
// 4999; no clearing pass is needed.
module disk_sweep_scheduler_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [dss_pkg::CYL_BITS-1:0]  in_request_cylinder,
  input  logic [dss_pkg::CYL_BITS-1:0]  in_head_cylinder,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dss_pkg::CYL_BITS-1:0]  out_path_cylinder,
  output logic                          out_last,
  output logic                          out_rejected,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dss_pkg::CYL_BITS-1:0]  cfg_data
);
  import dss_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE    = 15'b000000000000001,
    S_INS_RD  = 15'b000000000000010,
    S_INS_CMP = 15'b000000000000100,
    S_SPL_RD  = 15'b000000000001000,
    S_SPL_CMP = 15'b000000000010000,
    S_HEAD    = 15'b000000000100000,
    S_UP_RD   = 15'b000000001000000,
    S_UP_EM   = 15'b000000010000000,
    S_DN_RD   = 15'b000000100000000,
    S_DN_EM   = 15'b000001000000000,
    S_MAX     = 15'b000010000000000,
    S_ZERO    = 15'b000100000000000,
    S_LO_RD   = 15'b001000000000000,
    S_LO_EM   = 15'b010000000000000,
    S_REJ     = 15'b100000000000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     j_r, j_nxt;
  logic [CNT_W-1:0]     split_r, split_nxt;
  logic [CYL_BITS-1:0]  key_r, key_nxt;
  logic                 mode_r, mode_nxt;
  logic [CYL_BITS-1:0]  max_cyl_r, max_cyl_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CYL_BITS-1:0]  out_cyl_r, out_cyl_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_rej_r, out_rej_nxt;

  logic                 ram_we, ram_re;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [CYL_BITS-1:0]  ram_wdata, ram_rdata;

  logic [CNT_W-1:0]     jm1, jp1;
  logic                 out_free;
  logic                 em_valid, em_last, em_rej;
  logic [CYL_BITS-1:0]  em_cyl;

  assign jm1       = j_r - CNT_W'(1);
  assign jp1       = j_r + CNT_W'(1);
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign out_valid         = out_valid_r;
  assign out_path_cylinder = out_cyl_r;
  assign out_last          = out_last_r;
  assign out_rejected      = out_rej_r;

  // sorted request store
  dss_ram #(
    .WIDTH (CYL_BITS),
    .DEPTH (MAX_REQUESTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer: insertion on load, split search and path walk on start
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    j_nxt       = j_r;
    split_nxt   = split_r;
    key_nxt     = key_r;
    mode_nxt    = mode_r;
    max_cyl_nxt = max_cyl_r;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = j_r[ADDR_W-1:0];
    ram_wdata   = key_r;
    ram_raddr   = j_r[ADDR_W-1:0];
    em_valid    = 1'b0;
    em_cyl      = ram_rdata;
    em_last     = 1'b0;
    em_rej      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_LOAD) begin
            if (count_r == CNT_MAX) begin
              state_nxt = S_REJ;
            end else begin
              key_nxt   = in_request_cylinder;
              j_nxt     = count_r;
              state_nxt = S_INS_RD;
            end
          end else begin
            key_nxt   = in_head_cylinder;
            j_nxt     = '0;
            state_nxt = S_SPL_RD;
          end
        end
      end
      S_INS_RD: begin
        if (j_r == '0) begin
          ram_we    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          state_nxt = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = jm1[ADDR_W-1:0];
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        ram_we = 1'b1;
        if (ram_rdata > key_r) begin
          // move the larger entry up one place
          ram_wdata = ram_rdata;
          j_nxt     = jm1;
          state_nxt = S_INS_RD;
        end else begin
          count_nxt = count_r + CNT_W'(1);
          state_nxt = S_IDLE;
        end
      end
      S_SPL_RD: begin
        if (j_r == count_r) begin
          split_nxt = j_r;
          state_nxt = S_HEAD;
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_SPL_CMP;
        end
      end
      S_SPL_CMP: begin
        if (ram_rdata < key_r) begin
          j_nxt     = jp1;
          state_nxt = S_SPL_RD;
        end else begin
          split_nxt = j_r;
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        if (out_free) begin
          em_valid = 1'b1;
          em_cyl   = key_r;
          em_last  = (count_r == '0);
          j_nxt    = split_r;
          state_nxt = (count_r == '0) ? S_IDLE : S_UP_RD;
        end
      end
      S_UP_RD: begin
        if (j_r == count_r) begin
          // upper run done, lower entries remain
          if (mode_r == MODE_UP_DOWN) begin
            j_nxt     = split_r;
            state_nxt = S_DN_RD;
          end else begin
            state_nxt = S_MAX;
          end
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_UP_EM;
        end
      end
      S_UP_EM: begin
        if (out_free) begin
          em_valid = 1'b1;
          em_last  = (jp1 == count_r) && (split_r == '0);
          j_nxt    = jp1;
          if (em_last) begin
            count_nxt = '0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_UP_RD;
          end
        end
      end
      S_DN_RD: begin
        ram_re    = 1'b1;
        ram_raddr = jm1[ADDR_W-1:0];
        state_nxt = S_DN_EM;
      end
      S_DN_EM: begin
        if (out_free) begin
          em_valid = 1'b1;
          em_last  = (j_r == CNT_W'(1));
          j_nxt    = jm1;
          if (em_last) begin
            count_nxt = '0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_DN_RD;
          end
        end
      end
      S_MAX: begin
        if (out_free) begin
          em_valid  = 1'b1;
          em_cyl    = max_cyl_r;
          state_nxt = S_ZERO;
        end
      end
      S_ZERO: begin
        if (out_free) begin
          em_valid  = 1'b1;
          em_cyl    = '0;
          j_nxt     = '0;
          state_nxt = S_LO_RD;
        end
      end
      S_LO_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_LO_EM;
      end
      S_LO_EM: begin
        if (out_free) begin
          em_valid = 1'b1;
          em_last  = (jp1 == split_r);
          j_nxt    = jp1;
          if (em_last) begin
            count_nxt = '0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_LO_RD;
          end
        end
      end
      S_REJ: begin
        if (out_free) begin
          em_valid  = 1'b1;
          em_cyl    = '0;
          em_rej    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // configuration writes
    if (cfg_valid) begin
      if (cfg_index == CFG_SWEEP_MODE) begin
        mode_nxt = cfg_data[0];
      end else if (cfg_index == CFG_MAX_CYLINDER) begin
        max_cyl_nxt = cfg_data;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_cyl_nxt   = out_cyl_r;
    out_last_nxt  = out_last_r;
    out_rej_nxt   = out_rej_r;
    if (em_valid) begin
      out_valid_nxt = 1'b1;
      out_cyl_nxt   = em_cyl;
      out_last_nxt  = em_last;
      out_rej_nxt   = em_rej;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      mode_r      <= MODE_UP_DOWN;
      max_cyl_r   <= DEFAULT_MAX_CYL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      mode_r      <= mode_nxt;
      max_cyl_r   <= max_cyl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    j_r        <= j_nxt;
    split_r    <= split_nxt;
    key_r      <= key_nxt;
    out_cyl_r  <= out_cyl_nxt;
    out_last_r <= out_last_nxt;
    out_rej_r  <= out_rej_nxt;
  end

endmodule
